// ===== src/cvf_pkg.sv =====
`default_nettype none

package cvf_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned SUM_W  = 34;
  localparam int unsigned VIDX_W = 10;

  typedef enum logic {
    OP_STORE  = 1'b0,
    OP_ROTATE = 1'b1
  } op_e;

  // Queue entry: op, vertex index, the first edge and the edge sum; both edges are needed for the frame
  typedef struct packed {
    op_e                           op;
    logic [VIDX_W-1:0]             vidx;
    logic [2:0][DATA_W-1:0]        e1;
    logic [2:0][SUM_W-1:0]         sum;
  } item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MOD,
    ST_NORM,
    ST_SQ,
    ST_SQRT,
    ST_DIV,
    ST_CROSS,
    ST_STORE,
    ST_READ,
    ST_MAT,
    ST_OUT
  } state_e;

endpackage

`default_nettype wire

// ===== src/cvf_ram.sv =====
`default_nettype none

module cvf_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 9216
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ===== src/cvf_front.sv =====
`default_nettype none

module cvf_front (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  output logic                        in_ready_o,
  input  wire logic                   op_i,
  input  wire logic [9:0]             vertex_index_i,
  input  wire logic [8:0][31:0]       edges_i,
  output cvf_pkg::item_t              item_o,
  output logic                        item_valid_o,
  input  wire logic                   item_pop_i
);

  cvf_pkg::item_t entry_q [2];
  cvf_pkg::item_t new_item;
  logic           wr_ptr_q, rd_ptr_q;
  logic [1:0]     count_q;
  logic           push, pop;

  // Classify the item and pre-add the edges component by component
  always_comb begin
    new_item.op   = cvf_pkg::op_e'(op_i);
    new_item.vidx = vertex_index_i;
    for (int j = 0; j < 3; j++) begin
      new_item.e1[j]  = edges_i[j];
      new_item.sum[j] = {{2{edges_i[j][31]}}, edges_i[j]}
                      + {{2{edges_i[j+3][31]}}, edges_i[j+3]}
                      + {{2{edges_i[j+6][31]}}, edges_i[j+6]};
    end
  end

  assign in_ready_o   = (count_q != 2'd2);
  assign push         = in_valid_i & in_ready_o;
  assign item_valid_o = (count_q != 2'd0);
  assign pop          = item_pop_i & item_valid_o;
  assign item_o       = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= new_item;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      count_q <= count_q + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

`default_nettype wire

// ===== src/cvf_back.sv =====
`default_nettype none

module cvf_back #(
  parameter int unsigned VERTEX_COUNT = 1024
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire cvf_pkg::item_t               item_i,
  input  wire logic                         item_valid_i,
  output logic                              item_pop_o,
  output logic                              ram_we_o,
  output logic [$clog2(VERTEX_COUNT*9)-1:0] ram_waddr_o,
  output logic [31:0]                       ram_wdata_o,
  output logic [$clog2(VERTEX_COUNT*9)-1:0] ram_raddr_o,
  input  wire logic [31:0]                  ram_rdata_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic [8:0][31:0]                  rot_o,
  output logic [9:0]                        out_vertex_o
);

  localparam int unsigned AW = $clog2(VERTEX_COUNT * 9);
  localparam logic [16:0] VC = 17'(VERTEX_COUNT);

  cvf_pkg::state_e state_q, state_d;

  cvf_pkg::op_e       op_q;
  logic [9:0]         vidx_q, slot_q;
  logic signed [31:0] e1_q   [3];
  logic signed [33:0] vec_q  [3];
  logic               neg_q  [3];
  logic [30:0]        mag_q  [3];
  logic [63:0]        rad_q;
  logic [34:0]        rem_q;
  logic [31:0]        root_q;
  logic [16:0]        nl_q, quo_q;
  logic signed [31:0] n1_q [3];
  logic signed [31:0] e1u_q [3];
  logic signed [31:0] n2_q [3];
  logic signed [31:0] n3_q [3];
  logic [31:0]        rest_q [9];
  logic [8:0][31:0]   res_q;
  logic signed [63:0] prod_q;
  logic signed [65:0] acc_q;
  logic [4:0]         it_q;
  logic [1:0]         t_q, i_q, j_q, k_q;
  logic               term_q, ph_q, sel_q;
  logic [3:0]         cnt_q;
  logic [AW-1:0]      addr_q;
  logic               out_valid_q;
  logic [8:0][31:0]   rot_q;
  logic [9:0]         outv_q;

  logic [33:0]        absv [3];
  logic [33:0]        mmax, shtmp;
  logic [30:0]        shm [3];
  logic [5:0]         msb;
  logic               vzero;
  logic [34:0]        sq_r, sq_trial;
  logic               sq_ge;
  logic [47:0]        num;
  logic [32:0]        dv_r;
  logic               dv_ge;
  logic [16:0]        qn;
  logic signed [31:0] uval;
  logic signed [31:0] mul_a, mul_b;
  logic signed [65:0] prod_ext, acc_new;
  logic [31:0]        acc_rnd;
  logic [1:0]         ia, ib;
  logic [3:0]         rest_idx;
  logic [13:0]        slot9;
  logic               load_out, vec_done, div_last;

  function automatic logic [31:0] q16r(input logic signed [65:0] x);
    logic [65:0] m;
    logic [65:0] s;
    logic [49:0] r;
    logic [31:0] res;
    m = x[65] ? 66'(-x) : 66'(x);
    s = m + 66'd32768;
    r = s[65:16];
    if (!x[65]) begin
      res = (r > 50'h7FFFFFFF) ? 32'h7FFFFFFF : r[31:0];
    end else begin
      res = (r > 50'h80000000) ? 32'h80000000 : 32'(~r[31:0] + 32'd1);
    end
    return res;
  endfunction

  function automatic logic [1:0] add3(input logic [1:0] a, input logic [1:0] b);
    logic [2:0] s;
    s = {1'b0, a} + {1'b0, b};
    return (s >= 3'd3) ? 2'(s - 3'd3) : s[1:0];
  endfunction

  // Normalizing shift: bring the largest magnitude into [2^30, 2^31)
  always_comb begin
    msb = 6'd0;
    for (int j = 0; j < 3; j++) begin
      absv[j] = vec_q[j][33] ? 34'(-vec_q[j]) : 34'(vec_q[j]);
    end
    mmax = absv[0];
    if (absv[1] > mmax) mmax = absv[1];
    if (absv[2] > mmax) mmax = absv[2];
    for (int b = 0; b < 34; b++) begin
      if (mmax[b]) msb = 6'(b);
    end
    vzero = (mmax == 34'd0);
    for (int j = 0; j < 3; j++) begin
      if (msb < 6'd30) shtmp = absv[j] << (6'd30 - msb);
      else             shtmp = absv[j] >> (msb - 6'd30);
      shm[j] = shtmp[30:0];
    end
  end

  // One root bit per step
  assign sq_r     = {rem_q[32:0], rad_q[63:62]};
  assign sq_trial = {1'b0, root_q, 2'b01};
  assign sq_ge    = (sq_r >= sq_trial);

  // One quotient bit per step
  assign num   = {1'b0, mag_q[t_q], 16'd0} + {17'd0, root_q[31:1]};
  assign dv_r  = {rem_q[31:0], nl_q[16]};
  assign dv_ge = (dv_r >= {1'b0, root_q});
  assign qn    = {quo_q[15:0], dv_ge};
  assign uval  = neg_q[t_q] ? -$signed({15'd0, qn}) : $signed({15'd0, qn});

  assign ia       = add3(t_q, term_q ? 2'd2 : 2'd1);
  assign ib       = add3(t_q, term_q ? 2'd1 : 2'd2);
  assign rest_idx = {2'd0, j_q} * 4'd3 + {2'd0, k_q};
  assign slot9    = {slot_q, 3'd0} + {4'd0, slot_q};

  // Shared multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      cvf_pkg::ST_SQ: begin
        mul_a = $signed({1'b0, mag_q[t_q]});
        mul_b = $signed({1'b0, mag_q[t_q]});
      end
      cvf_pkg::ST_CROSS: begin
        mul_a = n1_q[ia];
        mul_b = sel_q ? n2_q[ib] : e1u_q[ib];
      end
      cvf_pkg::ST_MAT: begin
        case (k_q)
          2'd0:    mul_a = n1_q[i_q];
          2'd1:    mul_a = n2_q[i_q];
          default: mul_a = n3_q[i_q];
        endcase
        mul_b = $signed(rest_q[rest_idx]);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_ext = {{2{prod_q[63]}}, prod_q};
  assign acc_new  = (state_q == cvf_pkg::ST_CROSS && term_q) ? acc_q - prod_ext
                                                             : acc_q + prod_ext;
  assign acc_rnd  = q16r(acc_new);

  assign div_last = (state_q == cvf_pkg::ST_DIV) && (it_q == 5'd17);
  assign vec_done = ((state_q == cvf_pkg::ST_NORM) && vzero)
                  || (div_last && (t_q == 2'd2));

  // Next state and handshake strobes
  always_comb begin
    state_d    = state_q;
    item_pop_o = 1'b0;
    ram_we_o   = 1'b0;
    load_out   = 1'b0;
    unique case (state_q)
      cvf_pkg::ST_IDLE: begin
        if (item_valid_i) begin
          item_pop_o = 1'b1;
          state_d    = cvf_pkg::ST_MOD;
        end
      end
      cvf_pkg::ST_MOD: begin
        if ({7'd0, slot_q} < VC) state_d = cvf_pkg::ST_NORM;
      end
      cvf_pkg::ST_NORM: begin
        if (vzero) state_d = sel_q ? cvf_pkg::ST_CROSS : cvf_pkg::ST_NORM;
        else       state_d = cvf_pkg::ST_SQ;
      end
      cvf_pkg::ST_SQ: begin
        if (ph_q && t_q == 2'd2) state_d = cvf_pkg::ST_SQRT;
      end
      cvf_pkg::ST_SQRT: begin
        if (it_q == 5'd31) state_d = cvf_pkg::ST_DIV;
      end
      cvf_pkg::ST_DIV: begin
        if (vec_done) state_d = sel_q ? cvf_pkg::ST_CROSS : cvf_pkg::ST_NORM;
      end
      cvf_pkg::ST_CROSS: begin
        if (ph_q && term_q && t_q == 2'd2 && sel_q) begin
          state_d = (op_q == cvf_pkg::OP_STORE) ? cvf_pkg::ST_STORE : cvf_pkg::ST_READ;
        end
      end
      cvf_pkg::ST_STORE: begin
        ram_we_o = 1'b1;
        if (cnt_q == 4'd8) state_d = cvf_pkg::ST_IDLE;
      end
      cvf_pkg::ST_READ: begin
        if (cnt_q == 4'd9) state_d = cvf_pkg::ST_MAT;
      end
      cvf_pkg::ST_MAT: begin
        if (ph_q && k_q == 2'd2 && j_q == 2'd2 && i_q == 2'd2) state_d = cvf_pkg::ST_OUT;
      end
      cvf_pkg::ST_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          load_out = 1'b1;
          state_d  = cvf_pkg::ST_IDLE;
        end
      end
      default: state_d = cvf_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cvf_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Datapath and step counters
  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    case (state_q)
      cvf_pkg::ST_IDLE: begin
        op_q   <= item_i.op;
        vidx_q <= item_i.vidx;
        slot_q <= item_i.vidx;
        sel_q  <= 1'b0;
        for (int j = 0; j < 3; j++) begin
          e1_q[j]  <= $signed(item_i.e1[j]);
          vec_q[j] <= $signed(item_i.sum[j]);
        end
      end
      cvf_pkg::ST_MOD: begin
        if ({7'd0, slot_q} >= VC) slot_q <= slot_q - VC[9:0];
        else                      addr_q <= AW'(slot9);
      end
      cvf_pkg::ST_NORM: begin
        for (int j = 0; j < 3; j++) begin
          mag_q[j] <= shm[j];
          neg_q[j] <= vec_q[j][33];
          if (vzero) begin
            if (sel_q) e1u_q[j] <= '0;
            else       n1_q[j]  <= '0;
          end
        end
        rad_q  <= '0;
        rem_q  <= '0;
        root_q <= '0;
        t_q    <= 2'd0;
        ph_q   <= 1'b0;
      end
      cvf_pkg::ST_SQ: begin
        ph_q <= ~ph_q;
        if (ph_q) begin
          rad_q <= rad_q + 64'(prod_q);
          t_q   <= t_q + 2'd1;
          it_q  <= 5'd0;
        end
      end
      cvf_pkg::ST_SQRT: begin
        rem_q  <= sq_ge ? sq_r - sq_trial : sq_r;
        root_q <= {root_q[30:0], sq_ge};
        rad_q  <= rad_q << 2;
        it_q   <= it_q + 5'd1;
        t_q    <= 2'd0;
        if (it_q == 5'd31) it_q <= 5'd0;
      end
      cvf_pkg::ST_DIV: begin
        if (it_q == 5'd0) begin
          rem_q <= {4'd0, num[47:17]};
          nl_q  <= num[16:0];
          quo_q <= '0;
          it_q  <= 5'd1;
        end else begin
          rem_q <= dv_ge ? {2'd0, dv_r - {1'b0, root_q}} : {2'd0, dv_r};
          nl_q  <= {nl_q[15:0], 1'b0};
          quo_q <= qn;
          it_q  <= it_q + 5'd1;
          if (div_last) begin
            if (sel_q) e1u_q[t_q] <= uval;
            else       n1_q[t_q]  <= uval;
            it_q <= 5'd0;
            t_q  <= t_q + 2'd1;
          end
        end
      end
      cvf_pkg::ST_CROSS: begin
        ph_q <= ~ph_q;
        if (ph_q) begin
          if (term_q) begin
            if (sel_q) n3_q[t_q] <= acc_rnd;
            else       n2_q[t_q] <= acc_rnd;
            acc_q  <= '0;
            term_q <= 1'b0;
            if (t_q == 2'd2) begin
              t_q   <= 2'd0;
              sel_q <= 1'b1;
            end else begin
              t_q <= t_q + 2'd1;
            end
          end else begin
            acc_q  <= acc_new;
            term_q <= 1'b1;
          end
        end
        cnt_q <= 4'd0;
        i_q   <= 2'd0;
        k_q   <= 2'd0;
      end
      cvf_pkg::ST_STORE: begin
        addr_q <= addr_q + AW'(1);
        cnt_q  <= cnt_q + 4'd1;
        if (k_q == 2'd2) begin
          k_q <= 2'd0;
          i_q <= i_q + 2'd1;
        end else begin
          k_q <= k_q + 2'd1;
        end
      end
      cvf_pkg::ST_READ: begin
        if (cnt_q != 4'd9) addr_q <= addr_q + AW'(1);
        if (cnt_q != 4'd0) rest_q[cnt_q - 4'd1] <= ram_rdata_i;
        cnt_q <= cnt_q + 4'd1;
        i_q   <= 2'd0;
        j_q   <= 2'd0;
        k_q   <= 2'd0;
        ph_q  <= 1'b0;
        acc_q <= '0;
      end
      cvf_pkg::ST_MAT: begin
        ph_q <= ~ph_q;
        if (ph_q) begin
          if (k_q == 2'd2) begin
            res_q[{2'd0, i_q} * 4'd3 + {2'd0, j_q}] <= acc_rnd;
            acc_q <= '0;
            k_q   <= 2'd0;
            if (j_q == 2'd2) begin
              j_q <= 2'd0;
              i_q <= i_q + 2'd1;
            end else begin
              j_q <= j_q + 2'd1;
            end
          end else begin
            acc_q <= acc_new;
            k_q   <= k_q + 2'd1;
          end
        end
      end
      default: begin
      end
    endcase
    // Second vector pass: normalize the first edge
    if (vec_done && !sel_q) begin
      sel_q <= 1'b1;
      for (int j = 0; j < 3; j++) begin
        vec_q[j] <= {{2{e1_q[j][31]}}, e1_q[j]};
      end
    end
    if (vec_done && sel_q) begin
      sel_q  <= 1'b0;
      t_q    <= 2'd0;
      term_q <= 1'b0;
      ph_q   <= 1'b0;
      acc_q  <= '0;
    end
  end

  always_comb begin
    case (k_q)
      2'd0:    ram_wdata_o = n1_q[i_q];
      2'd1:    ram_wdata_o = n2_q[i_q];
      default: ram_wdata_o = n3_q[i_q];
    endcase
  end
  assign ram_waddr_o = addr_q;
  assign ram_raddr_o = addr_q;

  // Output register parts the sequencer from the consumer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      rot_q  <= res_q;
      outv_q <= vidx_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign rot_o        = rot_q;
  assign out_vertex_o = outv_q;

  a_sqrt_to_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == cvf_pkg::ST_SQRT && it_q == 5'd31) |=> state_q == cvf_pkg::ST_DIV)
    else $error("square root did not hand over to the divider");

  a_div_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == cvf_pkg::ST_DIV && it_q != 5'd0) |-> rem_q[31:0] < root_q)
    else $error("divider remainder not below the norm");

  a_store_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we_o |-> op_q == cvf_pkg::OP_STORE)
    else $error("rest frame write for a rotate item");

  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |=> (out_valid_q && state_q == cvf_pkg::ST_IDLE))
    else $error("result load lost");

endmodule

`default_nettype wire

// ===== src/corotational_vertex_frame_core.sv =====
`default_nettype none

// Channel   Direction  Handshake                   Payload
// in        input      in_valid_i / in_ready_o     op_i, vertex_index_i, edge1..3_{x,y,z}_i
// out       output     out_valid_o / out_ready_i   rot_00_o..rot_22_o, out_vertex_o
//
// One item at a time runs in the back sequencer, paced by the bit-per-cycle square root
// (32 steps) and divider (18 steps per component, up to six components) plus the shared
// 32x32 multiplier. Vertex indexes at or above VERTEX_COUNT are brought into range by
// repeated subtraction of the count.
// Reset clears the control state only; the rest frame memory holds garbage until written.
// A two-entry queue keeps taking items while the sequencer works, until it is full; a
// finished result waits in the output register; the next one stalls until it is taken.
module corotational_vertex_frame_core #(
  parameter int unsigned VERTEX_COUNT = 1024
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic        op_i,
  input  wire logic [9:0]  vertex_index_i,
  input  wire logic [31:0] edge1_x_i,
  input  wire logic [31:0] edge1_y_i,
  input  wire logic [31:0] edge1_z_i,
  input  wire logic [31:0] edge2_x_i,
  input  wire logic [31:0] edge2_y_i,
  input  wire logic [31:0] edge2_z_i,
  input  wire logic [31:0] edge3_x_i,
  input  wire logic [31:0] edge3_y_i,
  input  wire logic [31:0] edge3_z_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [31:0]      rot_00_o,
  output logic [31:0]      rot_01_o,
  output logic [31:0]      rot_02_o,
  output logic [31:0]      rot_10_o,
  output logic [31:0]      rot_11_o,
  output logic [31:0]      rot_12_o,
  output logic [31:0]      rot_20_o,
  output logic [31:0]      rot_21_o,
  output logic [31:0]      rot_22_o,
  output logic [9:0]       out_vertex_o
);

  localparam int unsigned DEPTH = VERTEX_COUNT * 9;
  localparam int unsigned AW    = $clog2(DEPTH);

  cvf_pkg::item_t   item;
  logic             item_valid, item_pop;
  logic             ram_we;
  logic [AW-1:0]    ram_waddr, ram_raddr;
  logic [31:0]      ram_wdata, ram_rdata;
  logic [8:0][31:0] rot;

  // Front: accept the transfer, pre-add the edges, queue the item
  cvf_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .op_i           (op_i),
    .vertex_index_i (vertex_index_i),
    .edges_i        ({edge3_z_i, edge3_y_i, edge3_x_i,
                      edge2_z_i, edge2_y_i, edge2_x_i,
                      edge1_z_i, edge1_y_i, edge1_x_i}),
    .item_o         (item),
    .item_valid_o   (item_valid),
    .item_pop_i     (item_pop)
  );

  // Back: build the frame, then store it or form the rotation
  cvf_back #(
    .VERTEX_COUNT (VERTEX_COUNT)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_i       (item),
    .item_valid_i (item_valid),
    .item_pop_o   (item_pop),
    .ram_we_o     (ram_we),
    .ram_waddr_o  (ram_waddr),
    .ram_wdata_o  (ram_wdata),
    .ram_raddr_o  (ram_raddr),
    .ram_rdata_i  (ram_rdata),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .rot_o        (rot),
    .out_vertex_o (out_vertex_o)
  );

  // Rest frames: nine words per vertex, row-major
  cvf_ram #(
    .WIDTH (32),
    .DEPTH (DEPTH)
  ) u_rest_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign rot_00_o = rot[0];
  assign rot_01_o = rot[1];
  assign rot_02_o = rot[2];
  assign rot_10_o = rot[3];
  assign rot_11_o = rot[4];
  assign rot_12_o = rot[5];
  assign rot_20_o = rot[6];
  assign rot_21_o = rot[7];
  assign rot_22_o = rot[8];

endmodule

`default_nettype wire
